// ===== rtl/core/fdsd_pkg.sv =====
// ----------------------------------------------------------------------------
// fdsd_pkg
// Types, codes and microcode ROM shared by the floppy disk service decoder.
// ----------------------------------------------------------------------------
package fdsd_pkg;

   // Served vector and function codes
   localparam logic [7:0] SERVICE_VECTOR = 8'h13;
   localparam logic [7:0] FN_RESET       = 8'h00;
   localparam logic [7:0] FN_STATUS      = 8'h01;
   localparam logic [7:0] FN_READ        = 8'h02;
   localparam logic [7:0] FN_WRITE       = 8'h03;
   localparam logic [7:0] FN_PARAMS      = 8'h08;
   localparam logic [7:0] FN_TYPE        = 8'h15;

   // Status bytes
   localparam logic [7:0] ST_OK          = 8'h00;
   localparam logic [7:0] ST_INVALID     = 8'h01;
   localparam logic [7:0] ST_NOT_FOUND   = 8'h04;
   localparam logic [7:0] ST_BAD_DRIVE   = 8'h0c;

   // Drive geometry and limits
   localparam logic [7:0]  DRIVE_TYPE_FLOPPY = 8'h04;
   localparam logic [15:0] GEOM_CX           = 16'h4f12;
   localparam logic [15:0] GEOM_DX           = 16'h0102;
   localparam logic [7:0]  FIXED_DISK_BASE   = 8'h80;
   localparam logic [7:0]  HEAD_LIMIT        = 8'd2;
   localparam logic [7:0]  TRACK_LIMIT       = 8'd80;
   localparam logic [7:0]  MAX_SECTOR        = 8'd18;
   localparam logic [7:0]  FLOPPY_LIMIT      = 8'd2;

   // Transfer direction
   localparam logic [1:0] XFER_NONE  = 2'd0;
   localparam logic [1:0] XFER_READ  = 2'd1;
   localparam logic [1:0] XFER_WRITE = 2'd2;

   // Control register indexes and reset values
   localparam logic [1:0]  CSR_HEAD_COUNT    = 2'd0;
   localparam logic [1:0]  CSR_SECTORS       = 2'd1;
   localparam logic [1:0]  CSR_SECTOR_BYTES  = 2'd2;
   localparam logic [1:0]  HEAD_COUNT_RST    = 2'd2;
   localparam logic [4:0]  SECTORS_RST       = 5'd18;
   localparam logic [10:0] SECTOR_BYTES_RST  = 11'd512;

   // Micro-operations of the datapath
   typedef enum logic [2:0] {
      OP_LOAD,
      OP_MAC_HEADS,
      OP_MAC_SECTORS,
      OP_MUL_OFFSET,
      OP_MUL_COUNT,
      OP_FINISH
   } uop_type;

   typedef enum logic {
      JC_NONE,
      JC_NO_XFER
   } jcond_type;

   typedef logic [2:0] step_type;

   localparam step_type STEP_FINISH = 3'd5;

   typedef struct packed {
      uop_type   op;
      jcond_type cond;
      step_type  target;
   } uword_type;

   // Sequencer to datapath
   typedef struct packed {
      logic    active;
      uop_type op;
   } uctl_type;

   // Datapath to sequencer
   typedef struct packed {
      logic xfer_ok;
      logic out_busy;
   } ustat_type;

   // Latched request
   typedef struct packed {
      logic [7:0]  vector_number;
      logic [7:0]  function_code;
      logic [7:0]  drive;
      logic [7:0]  head;
      logic [7:0]  track;
      logic [7:0]  sector;
      logic [7:0]  sector_count;
      logic [15:0] buffer_offset;
      logic [15:0] buffer_segment;
      logic [15:0] table_offset;
      logic [15:0] table_segment;
   } req_type;

   // Result word
   typedef struct packed {
      logic        handled;
      logic [7:0]  status_code;
      logic        carry_out;
      logic [1:0]  transfer_kind;
      logic [23:0] disk_offset;
      logic [20:0] memory_address;
      logic [23:0] byte_count;
      logic [7:0]  drive_type;
      logic [15:0] geometry_cx;
      logic [15:0] geometry_dx;
      logic [15:0] table_offset_out;
      logic [15:0] table_segment_out;
   } rsp_type;

   // Microprogram: build the block number, scale it, scale the count, finish.
   // Anything that is not a good read or write jumps straight to finish.
   function automatic uword_type ucode_rom(step_type step);
      uword_type w;
      case (step)
         3'd0:    w = '{op: OP_LOAD,        cond: JC_NO_XFER, target: STEP_FINISH};
         3'd1:    w = '{op: OP_MAC_HEADS,   cond: JC_NONE,    target: 3'd0};
         3'd2:    w = '{op: OP_MAC_SECTORS, cond: JC_NONE,    target: 3'd0};
         3'd3:    w = '{op: OP_MUL_OFFSET,  cond: JC_NONE,    target: 3'd0};
         3'd4:    w = '{op: OP_MUL_COUNT,   cond: JC_NONE,    target: 3'd0};
         default: w = '{op: OP_FINISH,      cond: JC_NONE,    target: 3'd0};
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/core/fdsd_useq.sv =====
// ----------------------------------------------------------------------------
// fdsd_useq
// Microcode sequencer: step counter over the control ROM with one
// conditional jump; holds on the finish step while the result slot is full.
// ----------------------------------------------------------------------------
module fdsd_useq
   import fdsd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  ustat_type stat,
   output uctl_type  ctl
);

   logic      running_ff, running_in;
   step_type  step_ff, step_in;
   uword_type word;

   assign word = ucode_rom(step_ff);

   // Next step
   always_comb begin
      running_in = running_ff;
      step_in    = step_ff;
      if (!running_ff) begin
         if (start) begin
            running_in = 1'b1;
            step_in    = '0;
         end
      end else begin
         case (word.op)
            OP_FINISH: begin
               if (!stat.out_busy) begin
                  running_in = 1'b0;
               end
            end
            default: begin
               if (word.cond == JC_NO_XFER && !stat.xfer_ok) begin
                  step_in = word.target;
               end else begin
                  step_in = step_ff + 3'd1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         step_ff    <= '0;
      end else begin
         running_ff <= running_in;
         step_ff    <= step_in;
      end
   end

   assign ctl.active = running_ff;
   assign ctl.op     = word.op;

endmodule

// ===== rtl/core/floppy_disk_service_decoder.sv =====
// ----------------------------------------------------------------------------
// floppy_disk_service_decoder
// Decodes one disk-service request for floppy drive 0 and returns one result.
// ----------------------------------------------------------------------------
// A request is taken when the block is not sequencing; req_stall stays high
// while the microprogram runs. A good read or write runs six program steps
// (track load, two multiply-adds for the block number, the offset and count
// scalings on one shared 16x11 multiply-add unit, then finish); every other
// request jumps from the track load straight to finish. The next request
// can be accepted the cycle after the result is written, even while that
// result is stalled.
// Control registers are written through csr_* while no request is in flight.
// ----------------------------------------------------------------------------
module floppy_disk_service_decoder
   import fdsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_vector_number,
   input  logic [7:0]  req_function_code,
   input  logic [7:0]  req_drive,
   input  logic [7:0]  req_head,
   input  logic [7:0]  req_track,
   input  logic [7:0]  req_sector,
   input  logic [7:0]  req_sector_count,
   input  logic [15:0] req_buffer_offset,
   input  logic [15:0] req_buffer_segment,
   input  logic [15:0] req_table_offset,
   input  logic [15:0] req_table_segment,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_handled,
   output logic [7:0]  rsp_status_code,
   output logic        rsp_carry_out,
   output logic [1:0]  rsp_transfer_kind,
   output logic [23:0] rsp_disk_offset,
   output logic [20:0] rsp_memory_address,
   output logic [23:0] rsp_byte_count,
   output logic [7:0]  rsp_drive_type,
   output logic [15:0] rsp_geometry_cx,
   output logic [15:0] rsp_geometry_dx,
   output logic [15:0] rsp_table_offset_out,
   output logic [15:0] rsp_table_segment_out,
   // control registers
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_data
);

   uctl_type  ctl;
   ustat_type stat;
   logic      accept;
   logic      finish;

   req_type     req_ff, req_in;
   rsp_type     rsp_ff, rsp_in, res;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  last_status_ff, last_status_in;
   logic [1:0]  head_count_ff, head_count_in;
   logic [4:0]  sectors_ff, sectors_in;
   logic [10:0] sector_bytes_ff, sector_bytes_in;
   logic [15:0] acc_ff, acc_in;
   logic [23:0] offset_ff, offset_in;
   logic [23:0] count_ff, count_in;

   logic [15:0] mul_a;
   logic [10:0] mul_b;
   logic [15:0] mul_add;
   logic [26:0] prod;
   logic        vec_ok;
   logic        rw_fn;
   logic        chs_ok;
   logic        store;

   // Sequencer
   fdsd_useq u_useq (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .stat  (stat),
      .ctl   (ctl)
   );

   assign req_stall     = ctl.active;
   assign accept        = req_valid && !req_stall;
   assign csr_ready     = !ctl.active;
   assign stat.out_busy = rsp_valid_ff && rsp_stall;
   assign finish        = ctl.active && ctl.op == OP_FINISH && !stat.out_busy;

   // Request latch
   always_comb begin
      req_in = req_ff;
      if (accept) begin
         req_in = '{vector_number:  req_vector_number,
                    function_code:  req_function_code,
                    drive:          req_drive,
                    head:           req_head,
                    track:          req_track,
                    sector:         req_sector,
                    sector_count:   req_sector_count,
                    buffer_offset:  req_buffer_offset,
                    buffer_segment: req_buffer_segment,
                    table_offset:   req_table_offset,
                    table_segment:  req_table_segment};
      end
   end

   // Address check
   assign vec_ok = req_ff.vector_number == SERVICE_VECTOR;
   assign rw_fn  = req_ff.function_code == FN_READ || req_ff.function_code == FN_WRITE;
   assign chs_ok = req_ff.drive == 8'd0 && req_ff.head < HEAD_LIMIT &&
                   req_ff.sector != 8'd0 && req_ff.sector <= MAX_SECTOR &&
                   req_ff.track < TRACK_LIMIT;
   assign stat.xfer_ok = vec_ok && rw_fn && chs_ok;

   // Shared multiply-add unit
   always_comb begin
      mul_a   = acc_ff;
      mul_b   = '0;
      mul_add = '0;
      case (ctl.op)
         OP_MAC_HEADS: begin
            mul_b   = {9'd0, head_count_ff};
            mul_add = {8'd0, req_ff.head};
         end
         OP_MAC_SECTORS: begin
            mul_b   = {6'd0, sectors_ff};
            mul_add = {8'd0, req_ff.sector - 8'd1};
         end
         OP_MUL_OFFSET: begin
            mul_b = sector_bytes_ff;
         end
         OP_MUL_COUNT: begin
            mul_a = {8'd0, req_ff.sector_count};
            mul_b = sector_bytes_ff;
         end
         default: begin
            mul_b = '0;
         end
      endcase
   end

   assign prod = {11'd0, mul_a} * {16'd0, mul_b} + {11'd0, mul_add};

   // Datapath registers
   always_comb begin
      acc_in    = acc_ff;
      offset_in = offset_ff;
      count_in  = count_ff;
      if (ctl.active) begin
         case (ctl.op)
            OP_LOAD:        acc_in    = {8'd0, req_ff.track};
            OP_MAC_HEADS:   acc_in    = prod[15:0];
            OP_MAC_SECTORS: acc_in    = prod[15:0];
            OP_MUL_OFFSET:  offset_in = prod[23:0];
            OP_MUL_COUNT:   count_in  = prod[23:0];
            default:        acc_in    = acc_ff;
         endcase
      end
   end

   // Result decode
   always_comb begin
      res   = '0;
      store = 1'b0;
      if (vec_ok) begin
         case (req_ff.function_code)
            FN_RESET: begin
               res.handled = 1'b1;
               store       = 1'b1;
               if (req_ff.drive != 8'd0) begin
                  res.status_code = ST_BAD_DRIVE;
                  res.carry_out   = 1'b1;
               end
            end
            FN_STATUS: begin
               res.handled     = 1'b1;
               res.status_code = last_status_ff;
            end
            FN_READ, FN_WRITE: begin
               res.handled = 1'b1;
               store       = 1'b1;
               if (!chs_ok) begin
                  res.status_code = ST_NOT_FOUND;
                  res.carry_out   = 1'b1;
               end else begin
                  res.transfer_kind  = (req_ff.function_code == FN_READ) ?
                                       XFER_READ : XFER_WRITE;
                  res.disk_offset    = offset_ff;
                  res.memory_address = {1'b0, req_ff.buffer_segment, 4'd0} +
                                       {5'd0, req_ff.buffer_offset};
                  res.byte_count     = count_ff;
               end
            end
            FN_PARAMS: begin
               res.handled = 1'b1;
               store       = 1'b1;
               if (req_ff.drive >= FIXED_DISK_BASE) begin
                  res.status_code = ST_INVALID;
                  res.carry_out   = 1'b1;
               end else begin
                  res.drive_type        = DRIVE_TYPE_FLOPPY;
                  res.geometry_cx       = GEOM_CX;
                  res.geometry_dx       = GEOM_DX;
                  res.table_offset_out  = req_ff.table_offset;
                  res.table_segment_out = req_ff.table_segment;
               end
            end
            FN_TYPE: begin
               res.handled     = 1'b1;
               store           = 1'b1;
               res.status_code = (req_ff.drive < FLOPPY_LIMIT) ? ST_INVALID : ST_OK;
            end
            default: begin
               store = 1'b0;
            end
         endcase
      end
   end

   // Result register and status memory
   always_comb begin
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff;
      last_status_in = last_status_ff;
      if (finish) begin
         rsp_in       = res;
         rsp_valid_in = 1'b1;
         if (store) begin
            last_status_in = res.status_code;
         end
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control register writes
   always_comb begin
      head_count_in   = head_count_ff;
      sectors_in      = sectors_ff;
      sector_bytes_in = sector_bytes_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HEAD_COUNT:   head_count_in   = csr_data[1:0];
            CSR_SECTORS:      sectors_in      = csr_data[4:0];
            CSR_SECTOR_BYTES: sector_bytes_in = csr_data;
            default:          head_count_in   = head_count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         last_status_ff  <= ST_OK;
         head_count_ff   <= HEAD_COUNT_RST;
         sectors_ff      <= SECTORS_RST;
         sector_bytes_ff <= SECTOR_BYTES_RST;
      end else begin
         rsp_valid_ff    <= rsp_valid_in;
         last_status_ff  <= last_status_in;
         head_count_ff   <= head_count_in;
         sectors_ff      <= sectors_in;
         sector_bytes_ff <= sector_bytes_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      rsp_ff    <= rsp_in;
      acc_ff    <= acc_in;
      offset_ff <= offset_in;
      count_ff  <= count_in;
   end

   // Outputs
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_handled           = rsp_ff.handled;
   assign rsp_status_code       = rsp_ff.status_code;
   assign rsp_carry_out         = rsp_ff.carry_out;
   assign rsp_transfer_kind     = rsp_ff.transfer_kind;
   assign rsp_disk_offset       = rsp_ff.disk_offset;
   assign rsp_memory_address    = rsp_ff.memory_address;
   assign rsp_byte_count        = rsp_ff.byte_count;
   assign rsp_drive_type        = rsp_ff.drive_type;
   assign rsp_geometry_cx       = rsp_ff.geometry_cx;
   assign rsp_geometry_dx       = rsp_ff.geometry_dx;
   assign rsp_table_offset_out  = rsp_ff.table_offset_out;
   assign rsp_table_segment_out = rsp_ff.table_segment_out;

endmodule

// ===== rtl/core/fdsd_check.sv =====
// ----------------------------------------------------------------------------
// fdsd_check
// Port-level checks for the floppy disk service decoder, bound to the top.
// ----------------------------------------------------------------------------
module fdsd_check
   import fdsd_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_handled,
   input logic [7:0] rsp_status_code,
   input logic       rsp_carry_out,
   input logic [1:0] rsp_transfer_kind
);

   // One request at a time: intake closes right after a request is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request intake open right after a request");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status_code)))
      else $error("stalled result changed");

   // A failure is a served call with a nonzero status and no transfer
   a_carry_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_carry_out) |->
         (rsp_handled && rsp_status_code != ST_OK && rsp_transfer_kind == XFER_NONE))
      else $error("carry without error status");

   // A transfer only comes from a successful served call
   a_xfer_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_transfer_kind != XFER_NONE) |->
         (rsp_handled && !rsp_carry_out && rsp_status_code == ST_OK))
      else $error("transfer on a failed call");

endmodule

bind floppy_disk_service_decoder fdsd_check u_fdsd_check (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_handled       (rsp_handled),
   .rsp_status_code   (rsp_status_code),
   .rsp_carry_out     (rsp_carry_out),
   .rsp_transfer_kind (rsp_transfer_kind)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the floppy disk service decoder. A directed table
// covers the special cases and field extremes. Random requests then run
// under several register settings, with random idle bursts on both channels.
// Results are checked against typed table rows or an in-bench model of the decoder.
// ----------------------------------------------------------------------------
module testbench
   import fdsd_pkg::*;
();

   localparam int N_PHASES    = 8;
   localparam int PHASE_ITEMS = 150;
   localparam int STUCK_LIMIT = 1000;
   localparam int END_CYCLES  = 10;

   // one row of the directed table
   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } case_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_vector_number = '0;
   logic [7:0]  req_function_code = '0;
   logic [7:0]  req_drive = '0;
   logic [7:0]  req_head = '0;
   logic [7:0]  req_track = '0;
   logic [7:0]  req_sector = '0;
   logic [7:0]  req_sector_count = '0;
   logic [15:0] req_buffer_offset = '0;
   logic [15:0] req_buffer_segment = '0;
   logic [15:0] req_table_offset = '0;
   logic [15:0] req_table_segment = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_handled;
   logic [7:0]  rsp_status_code;
   logic        rsp_carry_out;
   logic [1:0]  rsp_transfer_kind;
   logic [23:0] rsp_disk_offset;
   logic [20:0] rsp_memory_address;
   logic [23:0] rsp_byte_count;
   logic [7:0]  rsp_drive_type;
   logic [15:0] rsp_geometry_cx;
   logic [15:0] rsp_geometry_dx;
   logic [15:0] rsp_table_offset_out;
   logic [15:0] rsp_table_segment_out;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [10:0] csr_data = '0;

   // shadow of the block's registers and stored status
   logic [1:0]  head_count_q = HEAD_COUNT_RST;
   logic [4:0]  sectors_q = SECTORS_RST;
   logic [10:0] sector_bytes_q = SECTOR_BYTES_RST;
   logic [7:0]  last_status_q = ST_OK;

   rsp_type      pending_results[$];
   case_row_type disk_cases[$];
   bit           idle_on = 1'b1;
   int           n_errors = 0;
   int           n_requests = 0;
   int           n_results = 0;
   int           n_transfers = 0;
   int           n_settings = 0;
   int           stall_left = 0;
   int           stuck_cycles = 0;

   floppy_disk_service_decoder i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_vector_number     (req_vector_number),
      .req_function_code     (req_function_code),
      .req_drive             (req_drive),
      .req_head              (req_head),
      .req_track             (req_track),
      .req_sector            (req_sector),
      .req_sector_count      (req_sector_count),
      .req_buffer_offset     (req_buffer_offset),
      .req_buffer_segment    (req_buffer_segment),
      .req_table_offset      (req_table_offset),
      .req_table_segment     (req_table_segment),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_handled           (rsp_handled),
      .rsp_status_code       (rsp_status_code),
      .rsp_carry_out         (rsp_carry_out),
      .rsp_transfer_kind     (rsp_transfer_kind),
      .rsp_disk_offset       (rsp_disk_offset),
      .rsp_memory_address    (rsp_memory_address),
      .rsp_byte_count        (rsp_byte_count),
      .rsp_drive_type        (rsp_drive_type),
      .rsp_geometry_cx       (rsp_geometry_cx),
      .rsp_geometry_dx       (rsp_geometry_dx),
      .rsp_table_offset_out  (rsp_table_offset_out),
      .rsp_table_segment_out (rsp_table_segment_out),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   // clock, period 10
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Service decode: expected result of one request, updates the stored status
   function automatic rsp_type decode_service(req_type r);
      rsp_type         o;
      longint unsigned block_num;
      o = '0;
      if (r.vector_number != SERVICE_VECTOR) return o;
      case (r.function_code)
         FN_RESET: begin
            if (r.drive != 8'd0) begin
               o.status_code = ST_BAD_DRIVE;
               o.carry_out   = 1'b1;
            end
            last_status_q = o.status_code;
         end
         FN_STATUS: begin
            o.status_code = last_status_q;
         end
         FN_READ, FN_WRITE: begin
            if (r.drive != 8'd0 || r.head >= HEAD_LIMIT || r.sector == 8'd0 ||
                r.sector > MAX_SECTOR || r.track >= TRACK_LIMIT) begin
               o.status_code = ST_NOT_FOUND;
               o.carry_out   = 1'b1;
            end else begin
               block_num = (64'(r.track) * head_count_q + r.head) * sectors_q
                           + r.sector - 1;
               o.transfer_kind  = (r.function_code == FN_READ) ? XFER_READ : XFER_WRITE;
               o.disk_offset    = 24'(block_num * sector_bytes_q);
               o.memory_address = 21'({r.buffer_segment, 4'h0}) + 21'(r.buffer_offset);
               o.byte_count     = 24'(64'(r.sector_count) * sector_bytes_q);
            end
            last_status_q = o.status_code;
         end
         FN_PARAMS: begin
            if (r.drive >= FIXED_DISK_BASE) begin
               o.status_code = ST_INVALID;
               o.carry_out   = 1'b1;
            end else begin
               o.drive_type        = DRIVE_TYPE_FLOPPY;
               o.geometry_cx       = GEOM_CX;
               o.geometry_dx       = GEOM_DX;
               o.table_offset_out  = r.table_offset;
               o.table_segment_out = r.table_segment;
            end
            last_status_q = o.status_code;
         end
         FN_TYPE: begin
            o.status_code = (r.drive < FLOPPY_LIMIT) ? ST_INVALID : ST_OK;
            last_status_q = o.status_code;
         end
         default: return o;
      endcase
      o.handled = 1'b1;
      return o;
   endfunction

   // Directed row; typed rows carry handled, status and carry, all else zero
   task automatic add_case(input logic [7:0] vec, fn, drv, hd, trk, sec, cnt,
                           input logic [15:0] boff, bseg, toff, tseg,
                           input bit typed, input logic h,
                           input logic [7:0] st, input logic cy);
      case_row_type row;
      row.req   = '{vec, fn, drv, hd, trk, sec, cnt, boff, bseg, toff, tseg};
      row.typed = typed;
      row.rsp   = '0;
      row.rsp.handled     = h;
      row.rsp.status_code = st;
      row.rsp.carry_out   = cy;
      disk_cases.insert(disk_cases.size(), row);
   endtask

   // Random request: mostly served vector, known functions and good addresses
   function automatic req_type random_request();
      req_type r;
      int      pick;
      r.vector_number = ($urandom_range(0, 15) == 0) ? 8'($urandom) : SERVICE_VECTOR;
      pick = $urandom_range(0, 15);
      case (pick)
         0:       r.function_code = FN_RESET;
         1:       r.function_code = FN_STATUS;
         2, 3, 4: r.function_code = FN_READ;
         5, 6, 7: r.function_code = FN_WRITE;
         8, 9:    r.function_code = FN_PARAMS;
         10, 11:  r.function_code = FN_TYPE;
         default: r.function_code = 8'($urandom);
      endcase
      if ($urandom_range(0, 3) != 0) begin
         r.drive  = 8'd0;
         r.head   = 8'($urandom_range(0, 1));
         r.track  = 8'($urandom_range(0, 79));
         r.sector = 8'($urandom_range(1, 18));
      end else begin
         case ($urandom_range(0, 3))
            0:       r.drive = 8'($urandom_range(0, 2));
            1:       r.drive = FIXED_DISK_BASE - 8'($urandom_range(0, 1));
            default: r.drive = 8'($urandom);
         endcase
         r.head   = 8'($urandom);
         r.track  = 8'($urandom);
         r.sector = 8'($urandom);
         // half the time keep head and track near their limits
         if ($urandom_range(0, 1) == 0) begin
            r.head  = 8'($urandom_range(0, 2));
            r.track = 8'($urandom_range(78, 80));
         end
      end
      r.sector_count   = 8'($urandom);
      r.buffer_offset  = 16'($urandom);
      r.buffer_segment = 16'($urandom);
      r.table_offset   = 16'($urandom);
      r.table_segment  = 16'($urandom);
      return r;
   endfunction

   // Issue one request and queue its expected result at acceptance
   task automatic send_request(input req_type r, input bit typed, input rsp_type typed_rsp);
      rsp_type predicted;
      req_valid <= 1'b1;
      {req_vector_number, req_function_code, req_drive, req_head, req_track,
       req_sector, req_sector_count, req_buffer_offset, req_buffer_segment,
       req_table_offset, req_table_segment} <= r;
      do @(posedge clock); while (req_stall);
      predicted = decode_service(r);
      if (predicted.transfer_kind != XFER_NONE) n_transfers++;
      pending_results.insert(pending_results.size(), typed ? typed_rsp : predicted);
      n_requests++;
   endtask

   // Random gaps on the request side, now and then a full drain
   task automatic sender_gap();
      if (!idle_on) return;
      if ($urandom_range(0, 199) == 0) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (pending_results.size() != 0);
      end else if ($urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_HEAD_COUNT: head_count_q   = val[1:0];
         CSR_SECTORS:    sectors_q      = val[4:0];
         default:        sector_bytes_q = val;
      endcase
   endtask

   task automatic apply_setting(input logic [10:0] heads, spt, bytes);
      write_reg(CSR_HEAD_COUNT, heads);
      write_reg(CSR_SECTORS, spt);
      write_reg(CSR_SECTOR_BYTES, bytes);
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   task automatic compare_field(input string name, input longint unsigned exp_v,
                                input longint unsigned act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
         n_errors++;
      end
   endtask

   // Result side: random stall bursts and field-by-field check
   always @(posedge clock) begin
      rsp_type got, want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_handled, rsp_status_code, rsp_carry_out, rsp_transfer_kind,
                   rsp_disk_offset, rsp_memory_address, rsp_byte_count,
                   rsp_drive_type, rsp_geometry_cx, rsp_geometry_dx,
                   rsp_table_offset_out, rsp_table_segment_out};
            n_results++;
            if (pending_results.size() == 0) begin
               $error("result with no request outstanding: 0x%0h", got);
               n_errors++;
            end else begin
               want = pending_results.pop_front();
               compare_field("handled", want.handled, got.handled);
               compare_field("status_code", want.status_code, got.status_code);
               compare_field("carry_out", want.carry_out, got.carry_out);
               compare_field("transfer_kind", want.transfer_kind, got.transfer_kind);
               compare_field("disk_offset", want.disk_offset, got.disk_offset);
               compare_field("memory_address", want.memory_address, got.memory_address);
               compare_field("byte_count", want.byte_count, got.byte_count);
               compare_field("drive_type", want.drive_type, got.drive_type);
               compare_field("geometry_cx", want.geometry_cx, got.geometry_cx);
               compare_field("geometry_dx", want.geometry_dx, got.geometry_dx);
               compare_field("table_offset_out", want.table_offset_out,
                             got.table_offset_out);
               compare_field("table_segment_out", want.table_segment_out,
                             got.table_segment_out);
            end
         end
         if (!idle_on) begin
            rsp_stall <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left = stall_left - 1;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 16);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Cycles with no handshake on any channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
   end

   initial begin
      do @(posedge clock); while (stuck_cycles < STUCK_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Stimulus
   initial begin
      // vec  fn  drv  hd  trk  sec  cnt  boff  bseg  toff  tseg  typed h st cy
      add_case(8'h13, FN_STATUS, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
               16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 1, ST_OK, 0);
      // served function on another vector
      add_case(8'h12, FN_READ, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01,
               16'h1234, 16'h5678, 16'h0000, 16'h0000, 1, 0, ST_OK, 0);
      add_case(8'hff, FN_RESET, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
               16'hffff, 16'hffff, 16'hffff, 16'hffff, 1, 0, ST_OK, 0);
      // unknown functions
      add_case(8'h13, 8'h04, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01,
               16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 0, ST_OK, 0);
      add_case(8'h13, 8'hff, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01,
               16'h0000, 16'h0000, 16'hffff, 16'hffff, 1, 0, ST_OK, 0);
      // reset: good drive, then a missing one, then read the stored status
      add_case(8'h13, FN_RESET, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
               16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 1, ST_OK, 0);
      add_case(8'h13, FN_RESET, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00,
               16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 1, ST_BAD_DRIVE, 1);
      add_case(8'h13, FN_STATUS, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
               16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 1, ST_BAD_DRIVE, 0);
      // bad addresses: drive, head, sector zero, sector past 18, track 80
      add_case(8'h13, FN_READ, 8'h01, 8'h00, 8'h00, 8'h01, 8'h01,
               16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 1, ST_NOT_FOUND, 1);
      add_case(8'h13, FN_READ, 8'h00, 8'h02, 8'h00, 8'h01, 8'h01,
               16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 1, ST_NOT_FOUND, 1);
      add_case(8'h13, FN_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
               16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 1, ST_NOT_FOUND, 1);
      add_case(8'h13, FN_WRITE, 8'h00, 8'h01, 8'h4f, 8'h13, 8'hff,
               16'hffff, 16'hffff, 16'h0000, 16'h0000, 1, 1, ST_NOT_FOUND, 1);
      add_case(8'h13, FN_WRITE, 8'h00, 8'h00, 8'h50, 8'h01, 8'h01,
               16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 1, ST_NOT_FOUND, 1);
      add_case(8'h13, FN_STATUS, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
               16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 1, ST_NOT_FOUND, 0);
      // good transfers at the corners of the address range
      add_case(8'h13, FN_READ, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00,
               16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0, ST_OK, 0);
      add_case(8'h13, FN_READ, 8'h00, 8'h01, 8'h4f, 8'h12, 8'hff,
               16'hffff, 16'hffff, 16'hffff, 16'hffff, 0, 0, ST_OK, 0);
      add_case(8'h13, FN_WRITE, 8'h00, 8'h00, 8'h28, 8'h09, 8'h01,
               16'h8001, 16'h7ffe, 16'h0000, 16'h0000, 0, 0, ST_OK, 0);
      add_case(8'h13, FN_STATUS, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
               16'hffff, 16'hffff, 16'hffff, 16'hffff, 1, 1, ST_OK, 0);
      // drive parameters: fixed-disk range fails, floppies return geometry
      add_case(8'h13, FN_PARAMS, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00,
               16'h0000, 16'h0000, 16'hffff, 16'hffff, 1, 1, ST_INVALID, 1);
      add_case(8'h13, FN_PARAMS, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00,
               16'h0000, 16'h0000, 16'h1111, 16'h2222, 1, 1, ST_INVALID, 1);
      add_case(8'h13, FN_PARAMS, 8'h7f, 8'h00, 8'h00, 8'h00, 8'h00,
               16'h0000, 16'h0000, 16'hffff, 16'hffff, 0, 0, ST_OK, 0);
      add_case(8'h13, FN_PARAMS, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
               16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0, ST_OK, 0);
      // drive type stores its own status
      add_case(8'h13, FN_TYPE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
               16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 1, ST_INVALID, 0);
      add_case(8'h13, FN_TYPE, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00,
               16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 1, ST_OK, 0);
      add_case(8'h13, FN_TYPE, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
               16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 1, ST_INVALID, 0);
      add_case(8'h13, FN_STATUS, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
               16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 1, ST_INVALID, 0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table under the reset geometry
      foreach (disk_cases[i]) begin
         send_request(disk_cases[i].req, disk_cases[i].typed, disk_cases[i].rsp);
         sender_gap();
      end

      // random phases, each under its own register setting
      for (int ph = 0; ph < N_PHASES; ph++) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (pending_results.size() != 0);
         case (ph)
            0: apply_setting(11'(HEAD_COUNT_RST), 11'(SECTORS_RST), SECTOR_BYTES_RST);
            1: apply_setting(11'h003, 11'h01f, 11'h7ff);
            2: apply_setting(11'h000, 11'h000, 11'h000);
            3: apply_setting(11'h001, 11'h001, 11'd128);
            4: apply_setting(11'h002, 11'd18, 11'd1024);
            default: apply_setting(11'($urandom), 11'($urandom), 11'($urandom));
         endcase
         idle_on = (ph != N_PHASES - 1);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_request(random_request(), 1'b0, '0);
            sender_gap();
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (END_CYCLES) @(posedge clock);

      $display("Ran %0d requests (%0d from the directed table), checked %0d results,",
               n_requests, disk_cases.size(), n_results);
      $display("%0d of them good transfers, across %0d register settings.",
               n_transfers, n_settings);
      if (n_errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/fdsd_pkg.sv
rtl/core/fdsd_useq.sv
rtl/core/floppy_disk_service_decoder.sv
rtl/core/fdsd_check.sv
tb/testbench.sv
